// ----- hdl/pdd_pkg.sv -----
// ----------------------------------------------------------------------------
// pdd_pkg
// shared types and constants of the power-of-d dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package pdd_pkg;

  localparam int DEF_MAX_SERVERS = 16;
  localparam int DEF_MAX_SAMPLES = 8;
  localparam int DEF_MAX_IDLE    = 16;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_NUM_SERVERS   = 3'd0,
    CFG_SAMPLE_COUNT  = 3'd1,
    CFG_IDLE_LIMIT    = 3'd2,
    CFG_MEMORY_ENABLE = 3'd3,
    CFG_RANDOM_SEED   = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_ARRIVAL  = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_RESTART  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DISPATCH = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_RESTART  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_RESTART,
    S_BAD,
    S_CRD,
    S_CWR,
    S_MDRAW,
    S_MWAIT,
    S_MRD,
    S_MSEL,
    S_PINIT,
    S_PDRAW,
    S_PWAIT,
    S_PRD,
    S_PCRD,
    S_PCMP,
    S_SHRD,
    S_SHWR,
    S_PNEXT,
    S_PSEL,
    S_DROP,
    S_INCRD,
    S_INCWR,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_RESTART,
    OP_BAD,
    OP_CNT_RD_SID,
    OP_COMPLETE,
    OP_DRAW_IDLE,
    OP_DRAW_POOL,
    OP_IDLE_RD_DRAW,
    OP_SEL_MEM,
    OP_POOL_INIT,
    OP_POOL_RD,
    OP_PCNT_RD,
    OP_PCMP,
    OP_SHRD,
    OP_SHWR,
    OP_PNEXT,
    OP_SEL_SAMPLE,
    OP_DROP,
    OP_DROP_END,
    OP_INC,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  bad;
    logic  use_mem;
    logic  draw_busy;
    logic  pinit_last;
    logic  shift_more;
    logic  shift_more2;
    logic  k_last;
    logic  drop_done;
    logic  out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/power_of_d_dispatcher_with_idle_memory.sv -----
// ----------------------------------------------------------------------------
// power_of_d_dispatcher_with_idle_memory
// job dispatcher with per-server job counts and a remembered idle list
// ----------------------------------------------------------------------------
// One item is worked at a time. Each random draw runs the bit-serial
// remainder unit (32 steps). Both kinds of dispatch end with a compaction
// pass that walks the idle list; a sampled dispatch for n servers and d
// samples also rebuilds the pool and shifts its entries, going through a
// pool memory with one write port and one read port. A finished result sits
// in the output register while the next item is taken; a result still
// waiting there holds the next one in its last state.
`default_nettype none

module power_of_d_dispatcher_with_idle_memory #(
  parameter int MAX_SERVERS = pdd_pkg::DEF_MAX_SERVERS,
  parameter int MAX_SAMPLES = pdd_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_IDLE    = pdd_pkg::DEF_MAX_IDLE,
  parameter int COUNT_WIDTH = pdd_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [pdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [pdd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [7:0]                          s_tdata,  // completing server, idle flag
  input  wire logic [1:0]                          s_tuser,  // mode
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [23:0]                              m_tdata,  // chosen_server, job_count, bad_server
  output logic [1:0]                               m_tuser   // kind
);

  import pdd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [3:0]  out_srv;
  logic [15:0] out_cnt;
  logic        out_bad;

  pdd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .status(status), .cmd(cmd)
  );

  pdd_dp #(
    .MAX_SERVERS(MAX_SERVERS), .MAX_SAMPLES(MAX_SAMPLES),
    .MAX_IDLE(MAX_IDLE), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mode(s_tuser), .in_sid(s_tdata[3:0]), .in_idle(s_tdata[4]),
    .cmd(cmd), .status(status),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_kind(m_tuser), .out_srv(out_srv), .out_cnt(out_cnt), .out_bad(out_bad)
  );

  assign m_tdata = {3'd0, out_bad, out_cnt, out_srv};

endmodule

`default_nettype wire

// ----- hdl/pdd_ram.sv -----
// ----------------------------------------------------------------------------
// pdd_ram
// generic single-write, single-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/pdd_draw.sv -----
// ----------------------------------------------------------------------------
// pdd_draw
// galois lfsr with a bit-serial remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_draw #(
  parameter int ZW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire logic [31:0]   seed,
  input  wire logic          start,
  input  wire logic [ZW-1:0] size,
  output logic               busy,
  output logic [ZW-1:0]      result
);

  import pdd_pkg::*;

  logic [31:0]   lfsr;
  logic [31:0]   dividend;
  logic [ZW:0]   rem;
  logic [5:0]    cnt;
  logic [ZW-1:0] size_q;
  logic [31:0]   lfsr_next;
  logic [ZW:0]   rem_sh;
  logic [ZW:0]   rem_next;

  always_comb begin
    lfsr_next = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? LFSR_TAPS : 32'd0);
    rem_sh    = {rem[ZW-1:0], dividend[31]};
    rem_next  = (rem_sh >= {1'b0, size_q}) ? rem_sh - {1'b0, size_q} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= 32'd1;
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else if (load) begin
      lfsr <= (seed == 32'd0) ? 32'd1 : seed;
    end else if (start) begin
      lfsr     <= lfsr_next;
      dividend <= lfsr_next;
      size_q   <= size;
      rem      <= '0;
      cnt      <= 6'd32;
      busy     <= 1'b1;
    end else if (busy) begin
      rem      <= rem_next;
      dividend <= {dividend[30:0], 1'b0};
      cnt      <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign result = rem[ZW-1:0];

endmodule

`default_nettype wire

// ----- hdl/pdd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdd_ctrl
// sequencer for arrival, completion and restart items
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pdd_pkg::dp_status_t status,
  output pdd_pkg::dp_cmd_t         cmd
);

  import pdd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (status.mode)
          MODE_ARRIVAL:  state_next = status.use_mem ? S_MDRAW : S_PINIT;
          MODE_COMPLETE: state_next = status.bad ? S_BAD : S_CRD;
          MODE_RESTART:  state_next = S_RESTART;
          default:       state_next = S_IDLE;
        endcase
      end
      S_RESTART: state_next = S_DONE;
      S_BAD:     state_next = S_DONE;
      S_CRD:     state_next = S_CWR;
      S_CWR:     state_next = S_DONE;
      S_MDRAW:   state_next = S_MWAIT;
      S_MWAIT:   if (!status.draw_busy) state_next = S_MRD;
      S_MRD:     state_next = S_MSEL;
      S_MSEL:    state_next = S_DROP;
      S_PINIT:   if (status.pinit_last) state_next = S_PDRAW;
      S_PDRAW:   state_next = S_PWAIT;
      S_PWAIT:   if (!status.draw_busy) state_next = S_PRD;
      S_PRD:     state_next = S_PCRD;
      S_PCRD:    state_next = S_PCMP;
      S_PCMP:    state_next = status.shift_more ? S_SHRD : S_PNEXT;
      S_SHRD:    state_next = S_SHWR;
      S_SHWR:    state_next = status.shift_more2 ? S_SHRD : S_PNEXT;
      S_PNEXT:   state_next = status.k_last ? S_PSEL : S_PDRAW;
      S_PSEL:    state_next = S_DROP;
      S_DROP:    if (status.drop_done) state_next = S_INCRD;
      S_INCRD:   state_next = S_INCWR;
      S_INCWR:   state_next = S_DONE;
      S_DONE:    if (!status.out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_DECODE:  cmd.op = OP_PREP;
      S_RESTART: cmd.op = OP_RESTART;
      S_BAD:     cmd.op = OP_BAD;
      S_CRD:     cmd.op = OP_CNT_RD_SID;
      S_CWR:     cmd.op = OP_COMPLETE;
      S_MDRAW:   cmd.op = OP_DRAW_IDLE;
      S_MRD:     cmd.op = OP_IDLE_RD_DRAW;
      S_MSEL:    cmd.op = OP_SEL_MEM;
      S_PINIT:   cmd.op = OP_POOL_INIT;
      S_PDRAW:   cmd.op = OP_DRAW_POOL;
      S_PRD:     cmd.op = OP_POOL_RD;
      S_PCRD:    cmd.op = OP_PCNT_RD;
      S_PCMP:    cmd.op = OP_PCMP;
      S_SHRD:    cmd.op = OP_SHRD;
      S_SHWR:    cmd.op = OP_SHWR;
      S_PNEXT:   cmd.op = OP_PNEXT;
      S_PSEL:    cmd.op = OP_SEL_SAMPLE;
      S_DROP:    cmd.op = OP_DROP;
      S_INCRD:   cmd.op = OP_DROP_END;
      S_INCWR:   cmd.op = OP_INC;
      S_DONE:    if (!status.out_busy) cmd.op = OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/pdd_dp.sv -----
// ----------------------------------------------------------------------------
// pdd_dp
// datapath: config registers, job counts, idle list, sample pool, result
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_dp #(
  parameter int MAX_SERVERS = pdd_pkg::DEF_MAX_SERVERS,
  parameter int MAX_SAMPLES = pdd_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_IDLE    = pdd_pkg::DEF_MAX_IDLE,
  parameter int COUNT_WIDTH = pdd_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [pdd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [pdd_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  wire logic [1:0]                            in_mode,
  input  wire logic [3:0]                            in_sid,
  input  wire logic                                  in_idle,
  input  wire pdd_pkg::dp_cmd_t                      cmd,
  output pdd_pkg::dp_status_t                        status,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [1:0]                                 out_kind,
  output logic [3:0]                                 out_srv,
  output logic [15:0]                                out_cnt,
  output logic                                       out_bad
);

  import pdd_pkg::*;

  localparam int SW = $clog2(MAX_SERVERS);
  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam int IW = (MAX_IDLE > 1) ? $clog2(MAX_IDLE) : 1;
  localparam int LW = $clog2(MAX_IDLE + 1);
  localparam int DW = $clog2(MAX_SAMPLES + 1);
  localparam int ZW = (NW > LW) ? NW : LW;
  localparam int CW = COUNT_WIDTH;

  // configuration
  logic [4:0]  num_servers;
  logic [3:0]  sample_count;
  logic [4:0]  idle_limit;
  logic        memory_enable;
  logic [31:0] random_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers   <= 5'd16;
      sample_count  <= 4'd2;
      idle_limit    <= 5'd16;
      memory_enable <= 1'b1;
      random_seed   <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_NUM_SERVERS:   num_servers   <= cfg_data[4:0];
        CFG_SAMPLE_COUNT:  sample_count  <= cfg_data[3:0];
        CFG_IDLE_LIMIT:    idle_limit    <= cfg_data[4:0];
        CFG_MEMORY_ENABLE: memory_enable <= cfg_data[0];
        CFG_RANDOM_SEED:   random_seed   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [31:0]   n32, d32, lim32, rlen32;
  logic [NW-1:0] n_eff;
  logic [DW-1:0] d_eff;
  logic [LW-1:0] lim_eff;

  always_comb begin
    n32 = {27'd0, num_servers};
    if (n32 < 32'd1) n32 = 32'd1;
    if (n32 > 32'(MAX_SERVERS)) n32 = 32'(MAX_SERVERS);
    d32 = {28'd0, sample_count};
    if (d32 < 32'd1) d32 = 32'd1;
    if (d32 > 32'(MAX_SAMPLES)) d32 = 32'(MAX_SAMPLES);
    if (d32 > n32) d32 = n32;
    lim32 = {27'd0, idle_limit};
    if (lim32 > 32'(MAX_IDLE)) lim32 = 32'(MAX_IDLE);
    rlen32 = (lim32 > n32) ? n32 : lim32;
    n_eff   = NW'(n32);
    d_eff   = DW'(d32);
    lim_eff = LW'(lim32);
  end

  // reset contents of the idle list
  logic [SW-1:0] idle_init [MAX_IDLE];
  for (genvar g = 0; g < MAX_IDLE; g++) begin : g_idle_init
    assign idle_init[g] = SW'(g % MAX_SERVERS);
  end

  // item and working registers
  mode_t         mode_q;
  logic [3:0]    sid_q;
  logic          idle_q;
  logic [LW-1:0] len;
  logic [NW-1:0] left;
  logic [DW-1:0] k;
  logic [SW-1:0] idx;
  logic [SW-1:0] j;
  logic [LW-1:0] rptr;
  logic [LW-1:0] wptr;
  logic          rd_pend;
  logic [SW-1:0] cand;
  logic [SW-1:0] best;
  logic [CW-1:0] bestc;
  logic [SW-1:0] srv;
  logic [MAX_SERVERS-1:0] cvalid;
  logic [MAX_IDLE-1:0]    ivalid;
  logic [1:0]    res_kind;
  logic [3:0]    res_srv;
  logic [15:0]   res_cnt;
  logic          res_bad;

  // memories
  logic          c_we;
  logic [SW-1:0] c_waddr, c_raddr, c_raddr_q;
  logic [CW-1:0] c_wdata, c_rdata, c_val;
  logic          i_we;
  logic [IW-1:0] i_waddr, i_raddr, i_raddr_q;
  logic [SW-1:0] i_wdata, i_rdata, i_val;
  logic          p_we;
  logic [SW-1:0] p_waddr, p_raddr, p_wdata, p_rdata;

  pdd_ram #(.WIDTH(CW), .DEPTH(MAX_SERVERS)) u_counts (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  pdd_ram #(.WIDTH(SW), .DEPTH(MAX_IDLE)) u_idle (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rdata)
  );

  pdd_ram #(.WIDTH(SW), .DEPTH(MAX_SERVERS)) u_pool (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign c_val = cvalid[c_raddr_q] ? c_rdata : '0;
  assign i_val = ivalid[i_raddr_q] ? i_rdata : idle_init[i_raddr_q];

  // random draws
  logic          draw_load, draw_start, draw_busy;
  logic [ZW-1:0] draw_size, draw_res;

  pdd_draw #(.ZW(ZW)) u_draw (
    .clk(clk), .rst(rst), .load(draw_load), .seed(random_seed),
    .start(draw_start), .size(draw_size), .busy(draw_busy), .result(draw_res)
  );

  logic [CW-1:0] dec_val, inc_val;
  assign dec_val = (c_val == '0) ? '0 : c_val - CW'(1);
  assign inc_val = (c_val == {CW{1'b1}}) ? c_val : c_val + CW'(1);

  always_comb begin
    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
    i_we = 1'b0; i_waddr = '0; i_wdata = '0; i_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
    draw_load = 1'b0; draw_start = 1'b0; draw_size = '0;
    case (cmd.op)
      OP_RESTART: draw_load = 1'b1;
      OP_CNT_RD_SID: c_raddr = SW'(sid_q);
      OP_COMPLETE: begin
        c_we    = 1'b1;
        c_waddr = SW'(sid_q);
        c_wdata = dec_val;
        if (idle_q && (len < lim_eff)) begin
          i_we    = 1'b1;
          i_waddr = IW'(len);
          i_wdata = SW'(sid_q);
        end
      end
      OP_DRAW_IDLE: begin
        draw_start = 1'b1;
        draw_size  = ZW'(len);
      end
      OP_DRAW_POOL: begin
        draw_start = 1'b1;
        draw_size  = ZW'(left);
      end
      OP_IDLE_RD_DRAW: i_raddr = IW'(draw_res);
      OP_POOL_INIT: begin
        p_we    = 1'b1;
        p_waddr = idx;
        p_wdata = idx;
      end
      OP_POOL_RD: p_raddr = SW'(draw_res);
      OP_PCNT_RD: c_raddr = p_rdata;
      OP_SHRD:    p_raddr = j + SW'(1);
      OP_SHWR: begin
        p_we    = 1'b1;
        p_waddr = j;
        p_wdata = p_rdata;
      end
      OP_DROP: begin
        // compaction walk: read one entry ahead, keep those that differ
        if (rd_pend && (i_val != srv)) begin
          i_we    = 1'b1;
          i_waddr = IW'(wptr);
          i_wdata = i_val;
        end
        if (rptr < len) i_raddr = IW'(rptr);
      end
      OP_DROP_END: c_raddr = srv;
      OP_INC: begin
        c_we    = 1'b1;
        c_waddr = srv;
        c_wdata = inc_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    c_raddr_q <= c_raddr;
    i_raddr_q <= i_raddr;
    if (rst) begin
      cvalid    <= '0;
      ivalid    <= '0;
      len       <= LW'(MAX_IDLE < 16 ? MAX_IDLE : 16);
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (c_we) cvalid[c_waddr] <= 1'b1;
      if (i_we) ivalid[i_waddr] <= 1'b1;
      case (cmd.op)
        OP_LOAD: begin
          mode_q <= mode_t'(in_mode);
          sid_q  <= in_sid;
          idle_q <= in_idle;
        end
        OP_PREP: begin
          idx     <= '0;
          left    <= n_eff;
          k       <= '0;
          rptr    <= '0;
          wptr    <= '0;
          rd_pend <= 1'b0;
        end
        OP_RESTART: begin
          cvalid   <= '0;
          ivalid   <= '0;
          len      <= LW'(rlen32);
          res_kind <= KIND_RESTART;
          res_srv  <= 4'd0;
          res_cnt  <= 16'd0;
          res_bad  <= 1'b0;
        end
        OP_BAD: begin
          res_kind <= KIND_COMPLETE;
          res_srv  <= sid_q;
          res_cnt  <= 16'd0;
          res_bad  <= 1'b1;
        end
        OP_COMPLETE: begin
          if (idle_q && (len < lim_eff)) len <= len + LW'(1);
          res_kind <= KIND_COMPLETE;
          res_srv  <= sid_q;
          res_cnt  <= 16'(dec_val);
          res_bad  <= 1'b0;
        end
        OP_SEL_MEM:   srv <= i_val;
        OP_POOL_INIT: idx <= idx + SW'(1);
        OP_POOL_RD:   j   <= SW'(draw_res);
        OP_PCNT_RD:   cand <= p_rdata;
        OP_PCMP: begin
          if ((k == '0) || (c_val < bestc)) begin
            best  <= cand;
            bestc <= c_val;
          end
        end
        OP_SHWR: j <= j + SW'(1);
        OP_PNEXT: begin
          left <= left - NW'(1);
          k    <= k + DW'(1);
        end
        OP_SEL_SAMPLE: srv <= best;
        OP_DROP: begin
          if (rd_pend && (i_val != srv)) wptr <= wptr + LW'(1);
          if (rptr < len) begin
            rptr    <= rptr + LW'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
        end
        OP_DROP_END: len <= wptr;
        OP_INC: begin
          res_kind <= KIND_DISPATCH;
          res_srv  <= 4'(srv);
          res_cnt  <= 16'(inc_val);
          res_bad  <= 1'b0;
        end
        OP_EMIT: begin
          out_valid <= 1'b1;
          out_kind  <= res_kind;
          out_srv   <= res_srv;
          out_cnt   <= res_cnt;
          out_bad   <= res_bad;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.mode        = mode_q;
    status.bad         = ({28'd0, sid_q} >= n32);
    status.use_mem     = memory_enable && (len != '0);
    status.draw_busy   = draw_busy;
    status.pinit_last  = (32'(idx) + 32'd1 == n32);
    status.shift_more  = (32'(j) + 32'd1 < 32'(left));
    status.shift_more2 = (32'(j) + 32'd2 < 32'(left));
    status.k_last      = (32'(k) + 32'd1 == 32'(d_eff));
    status.drop_done   = !(rptr < len) && !rd_pend;
    status.out_busy    = out_valid && !out_ready;
  end

endmodule

`default_nettype wire
